// File: hdl/scv_pkg.sv
// ----------------------------------------------------------------------------
// scv_pkg: shared constants, tables and helpers for the scanner chorus/vibrato
// Memory sizes, configuration register codes, scanner tap tables, tap gain
// ROM, smoothing depth per mode and the quarter-sine polynomial terms.
// ----------------------------------------------------------------------------
`default_nettype none

package scv_pkg;

	// history and smoother memory geometry
	localparam int HIST_DEPTH = 1024;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int STAGES     = 9;
	localparam int STAGE_AW   = $clog2(STAGES);
	localparam int SCAN_STEPS = 32;
	localparam int STEP_W     = $clog2(SCAN_STEPS);

	// configuration register codes
	typedef enum logic [2:0] {
		CFG_DEPTH_MODE    = 3'd0,
		CFG_TAP_SPACING   = 3'd1,
		CFG_DAMPING       = 3'd2,
		CFG_DRY_GAIN      = 3'd3,
		CFG_CHORUS_ENABLE = 3'd4,
		CFG_SCAN_PERIOD   = 3'd5
	} cfg_reg_t;

	// configuration reset values
	localparam logic [1:0]  RST_DEPTH_MODE  = 2'd1;
	localparam logic [6:0]  RST_TAP_SPACING = 7'd2;
	localparam logic [15:0] RST_DAMPING     = 16'd64880;
	localparam logic [15:0] RST_DRY_GAIN    = 16'd52429;
	localparam logic [8:0]  RST_SCAN_PERIOD = 9'd198;

	// vibrato output scale, Q0.16 (0.7)
	localparam logic [15:0] VIB_GAIN = 16'd45875;

	// quarter-sine odd polynomial, Q16
	localparam logic [16:0] SIN_C1 = 17'd102944;
	localparam logic [16:0] SIN_C3 = 17'd42335;
	localparam logic [16:0] SIN_C5 = 17'd5223;
	localparam logic [16:0] SIN_C7 = 17'd307;
	localparam logic [16:0] SIN_ONE = 17'd65536;

	// scanner tables, period 16, entry i in nibble i
	typedef enum logic [2:0] {SEQ_A, SEQ_B, SEQ_C, SEQ_D, SEQ_E, SEQ_F, SEQ_Z} seq_id_t;

	localparam logic [63:0] SEQ_A_TAB = 64'h1234_5678_7654_3210;
	localparam logic [63:0] SEQ_B_TAB = 64'h0123_4567_8765_4321;
	localparam logic [63:0] SEQ_C_TAB = 64'h4433_2211_0011_2233;
	localparam logic [63:0] SEQ_D_TAB = 64'h3443_3221_1001_1223;
	localparam logic [63:0] SEQ_E_TAB = 64'h5566_7788_7766_5544;
	localparam logic [63:0] SEQ_F_TAB = 64'h4556_6778_8776_6554;
	localparam logic [63:0] SEQ_Z_TAB = 64'h7777_7777_7777_7777;

	function automatic logic [63:0] seq_bits(input seq_id_t id);
		unique case (id)
			SEQ_A:   seq_bits = SEQ_A_TAB;
			SEQ_B:   seq_bits = SEQ_B_TAB;
			SEQ_C:   seq_bits = SEQ_C_TAB;
			SEQ_D:   seq_bits = SEQ_D_TAB;
			SEQ_E:   seq_bits = SEQ_E_TAB;
			SEQ_F:   seq_bits = SEQ_F_TAB;
			default: seq_bits = SEQ_Z_TAB;
		endcase
	endfunction

	// table used by mix lane for a given (effective) mode
	function automatic seq_id_t lane_seq(input logic [1:0] mode, input logic [2:0] lane);
		seq_id_t id;
		id = SEQ_Z;
		if (mode == 2'd2) begin
			unique case (lane)
				3'd0:    id = SEQ_E;
				3'd1:    id = SEQ_F;
				3'd4:    id = SEQ_A;
				3'd5:    id = SEQ_B;
				default: id = SEQ_Z;
			endcase
		end else if (mode == 2'd3) begin
			unique case (lane)
				3'd0:    id = SEQ_E;
				3'd1:    id = SEQ_F;
				3'd2:    id = SEQ_C;
				3'd3:    id = SEQ_D;
				3'd4:    id = SEQ_A;
				3'd5:    id = SEQ_B;
				default: id = SEQ_Z;
			endcase
		end else begin
			unique case (lane)
				3'd0:    id = SEQ_A;
				3'd1:    id = SEQ_B;
				default: id = SEQ_Z;
			endcase
		end
		return id;
	endfunction

	// smoother index selected by a lane at a scanner step
	function automatic logic [STAGE_AW-1:0] tap_sel(input logic [1:0] mode,
			input logic [2:0] lane, input logic [STEP_W-1:0] step);
		logic [63:0] bits;
		bits = seq_bits(lane_seq(mode, lane));
		return STAGE_AW'(bits[{step[3:0], 2'b00} +: 4]);
	endfunction

	// tap gain, Q1.16, 1.00 .. 1.08
	function automatic logic [16:0] gain_of(input logic [STAGE_AW-1:0] idx);
		unique case (idx)
			4'd0:    gain_of = 17'd65536;
			4'd1:    gain_of = 17'd66191;
			4'd2:    gain_of = 17'd66847;
			4'd3:    gain_of = 17'd67502;
			4'd4:    gain_of = 17'd68157;
			4'd5:    gain_of = 17'd68813;
			4'd6:    gain_of = 17'd69468;
			4'd7:    gain_of = 17'd70124;
			4'd8:    gain_of = 17'd70779;
			default: gain_of = 17'd65536;
		endcase
	endfunction

	// smoothing depth per effective mode, Q0.16
	function automatic logic [15:0] depth_of(input logic [1:0] mode);
		unique case (mode)
			2'd2:    depth_of = 16'd62259;
			2'd3:    depth_of = 16'd58982;
			default: depth_of = 16'd6554;
		endcase
	endfunction

	// minimum tap spacing per effective mode
	function automatic logic [6:0] min_spacing_of(input logic [1:0] mode);
		unique case (mode)
			2'd2:    min_spacing_of = 7'd3;
			2'd3:    min_spacing_of = 7'd4;
			default: min_spacing_of = 7'd2;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: hdl/scanner_chorus_vibrato.sv
// ----------------------------------------------------------------------------
// scanner_chorus_vibrato: scanner vibrato / chorus on a tapped delay line
// Nine delayed taps of a sample history feed one-pole smoothers; a 32-step
// scanner crossfades tap pairs and mixes them (chorus or vibrato).
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  input    | in_valid / in_ready  | sample_in  (16b signed Q1.15)
//  output   | out_valid/ out_ready | sample_out (16b signed Q1.15)
//  config   | cfg_valid/ cfg_ready | cfg_index (3b), cfg_data (16b)
//
//  One word at a time: no input word is taken until the smoother pass over
//  the history and smoother RAMs (read, difference, update per tap), the
//  gain latch on a scanner step, the phase divider, the sine unit and the mix
//  are through with the last one. After reset a clearing pass zeroes the
//  history; no input word is taken during it. Config is always ready. A
//  finished word waits in the output register while the next input word is
//  processed.
`default_nettype none

module scanner_chorus_vibrato (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic signed [15:0] sample_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [15:0] sample_out,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	import scv_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_TAP, ST_HWR, ST_GAIN, ST_DIV,
		ST_SINE, ST_MIX, ST_FIN0, ST_FIN1, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [1:0]  mode_q;
	logic [6:0]  spacing_q;
	logic [15:0] damping_q;
	logic [15:0] dry_q;
	logic        chorus_q;
	logic [8:0]  period_q;

	logic [1:0]  mode_eff;
	logic [6:0]  sp_eff;
	logic [8:0]  period_eff;
	logic [6:0]  sp_min;

	// sequencing and architectural state
	logic [HIST_AW-1:0]  clr_q;
	logic [HIST_AW-1:0]  wp_q;
	logic [HIST_AW-1:0]  addr_q;
	logic [3:0]          k_q;
	logic [1:0]          ph_q;
	logic [8:0]          tick_q;
	logic [STEP_W-1:0]   step_q;
	logic [16:0]         gain_q [6];

	// datapath registers
	logic signed [15:0]  x_in_q;
	logic [15:0]         c_q;
	logic [15:0]         a_q;
	logic signed [24:0]  diff_q;
	logic signed [23:0]  s_q;
	logic [8:0]          rem_q;
	logic [15:0]         quo_q;
	logic [3:0]          dcnt_q;
	logic                sine_start_q;
	logic                sine_sel_q;
	logic [16:0]         up_q;
	logic [16:0]         down_q;
	logic signed [25:0]  p_q;
	logic signed [43:0]  acc_q;
	logic [36:0]         lo_q;
	logic signed [32:0]  dp_q;
	logic signed [15:0]  res_q;
	logic                out_valid_q;
	logic signed [15:0]  sample_out_q;

	// memories
	logic                hist_we;
	logic [HIST_AW-1:0]  hist_waddr;
	logic [15:0]         hist_wdata;
	logic [15:0]         hist_rdata;
	logic                st_we;
	logic [STAGE_AW-1:0] st_waddr;
	logic [23:0]         st_wdata;
	logic [STAGE_AW-1:0] st_raddr;
	logic [23:0]         st_rdata;

	// sine unit
	logic [16:0]         sine_x;
	logic                sine_done;
	logic [16:0]         sine_r;

	// combinational datapath
	logic [32:0]         c_next;
	logic [32:0]         a_next;
	logic signed [24:0]  diff_c;
	logic signed [41:0]  upd_rnd;
	logic signed [23:0]  s_new;
	logic [9:0]          tick_n;
	logic [STAGE_AW-1:0] lane_idx;
	logic [16:0]         g_c;
	logic [33:0]         g_wet;
	logic [9:0]          rem2;
	logic [16:0]         fade;
	logic signed [41:0]  pf_rnd;
	logic signed [43:0]  term;
	logic [2:0]          last_lane;
	logic signed [39:0]  hi_c;
	logic signed [60:0]  vib_tot;
	logic signed [44:0]  ch_tot;
	logic signed [20:0]  res_pre;
	logic signed [15:0]  res_sat;

	assign in_ready   = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// effective config
	always_comb begin
		mode_eff   = (mode_q == 2'd0) ? 2'd1 : mode_q;
		sp_min     = min_spacing_of(mode_eff);
		sp_eff     = (spacing_q < sp_min) ? sp_min : spacing_q;
		period_eff = (period_q == 9'd0) ? 9'd1 : period_q;
	end

	// smoother update arithmetic
	always_comb begin
		c_next  = 33'(c_q) * 33'(damping_q) + 33'd32768;
		a_next  = 33'(c_q) * 33'(depth_of(mode_eff)) + 33'd32768;
		diff_c  = $signed({hist_rdata[15], hist_rdata, 8'h00}) -
			$signed({st_rdata[23], st_rdata});
		upd_rnd = diff_q * $signed({1'b0, a_q}) + 42'sd32768;
		s_new   = s_q + upd_rnd[39:16];
	end

	// scanner, divider and mix arithmetic
	always_comb begin
		tick_n    = 10'(tick_q) + 10'd1;
		lane_idx  = tap_sel(mode_eff, k_q[2:0], step_q);
		g_c       = gain_of(lane_idx);
		g_wet     = 34'(g_c) * (34'd65536 - 34'(dry_q)) + 34'd32768;
		rem2      = {rem_q, 1'b0};
		fade      = k_q[0] ? up_q : down_q;
		pf_rnd    = $signed(st_rdata) * $signed({1'b0, fade}) + 42'sd32768;
		term      = p_q * $signed({1'b0, gain_q[k_q[2:0]]});
		last_lane = chorus_q ? 3'd5 : 3'd1;
		sine_x    = sine_sel_q ? (17'd65536 - {1'b0, quo_q}) : {1'b0, quo_q};
	end

	// output scaling and saturation
	always_comb begin
		hi_c    = $signed(acc_q[43:21]) * $signed({1'b0, VIB_GAIN});
		vib_tot = $signed({hi_c, 21'b0}) + $signed({24'b0, lo_q}) +
			(61'sd1 <<< 39);
		ch_tot  = $signed({{3{dp_q[32]}}, dp_q, 9'b0}) +
			$signed({acc_q[43], acc_q}) + 45'sd16777216;
		res_pre = chorus_q ? $signed({ch_tot[44], ch_tot[44:25]}) : vib_tot[60:40];
		if (res_pre > 21'sd32767) begin
			res_sat = 16'sd32767;
		end else if (res_pre < -21'sd32768) begin
			res_sat = -16'sd32768;
		end else begin
			res_sat = res_pre[15:0];
		end
	end

	// memory ports
	always_comb begin
		hist_we    = 1'b0;
		hist_waddr = wp_q;
		hist_wdata = x_in_q;
		st_we      = 1'b0;
		st_waddr   = k_q;
		st_wdata   = s_new;
		st_raddr   = (state_q == ST_MIX) ? lane_idx : k_q;
		if (state_q == ST_CLEAR) begin
			hist_we    = 1'b1;
			hist_waddr = clr_q;
			hist_wdata = 16'd0;
			st_we      = (clr_q < HIST_AW'(STAGES));
			st_waddr   = clr_q[STAGE_AW-1:0];
			st_wdata   = 24'd0;
		end else if (state_q == ST_HWR) begin
			hist_we = 1'b1;
		end else if (state_q == ST_TAP && ph_q == 2'd2) begin
			st_we = 1'b1;
		end
	end

	scv_ram #(.WIDTH(16), .DEPTH(HIST_DEPTH)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (addr_q),
		.rdata (hist_rdata)
	);

	scv_ram #(.WIDTH(24), .DEPTH(STAGES)) u_stage (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	scv_sine u_sine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sine_start_q),
		.x      (sine_x),
		.done   (sine_done),
		.result (sine_r)
	);

	// sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			mode_q       <= RST_DEPTH_MODE;
			spacing_q    <= RST_TAP_SPACING;
			damping_q    <= RST_DAMPING;
			dry_q        <= RST_DRY_GAIN;
			chorus_q     <= 1'b0;
			period_q     <= RST_SCAN_PERIOD;
			wp_q         <= '0;
			k_q          <= 4'd0;
			ph_q         <= 2'd0;
			tick_q       <= 9'd0;
			step_q       <= '0;
			for (int i = 0; i < 6; i++) begin
				gain_q[i] <= 17'd0;
			end
			sine_start_q <= 1'b0;
			sine_sel_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			sine_start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + HIST_AW'(1);
					if (clr_q == HIST_AW'(HIST_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (in_valid) begin
						x_in_q  <= sample_in;
						wp_q    <= wp_q - HIST_AW'(1);
						addr_q  <= wp_q - HIST_AW'(1) + HIST_AW'(sp_eff);
						k_q     <= 4'd0;
						ph_q    <= 2'd0;
						state_q <= ST_TAP;
					end
				end

				// per tap, in order: read, difference, update
				ST_TAP: begin
					unique case (ph_q)
						2'd0: begin
							c_q  <= (k_q == 4'd0) ? damping_q : c_next[31:16];
							ph_q <= 2'd1;
						end
						2'd1: begin
							a_q    <= a_next[31:16];
							diff_q <= diff_c;
							s_q    <= $signed(st_rdata);
							ph_q   <= 2'd2;
						end
						default: begin
							addr_q <= addr_q + HIST_AW'(sp_eff);
							ph_q   <= 2'd0;
							if (k_q == 4'(STAGES - 1)) begin
								state_q <= ST_HWR;
							end else begin
								k_q <= k_q + 4'd1;
							end
						end
					endcase
				end

				// history write and scanner tick
				ST_HWR: begin
					quo_q  <= 16'd0;
					dcnt_q <= 4'd0;
					k_q    <= 4'd0;
					if (tick_n >= {1'b0, period_eff}) begin
						tick_q  <= 9'd0;
						rem_q   <= 9'd0;
						step_q  <= step_q + STEP_W'(1);
						state_q <= ST_GAIN;
					end else begin
						tick_q  <= tick_n[8:0];
						rem_q   <= tick_n[8:0];
						state_q <= ST_DIV;
					end
				end

				// latch tap gains, one lane a cycle
				ST_GAIN: begin
					if (chorus_q) begin
						gain_q[k_q[2:0]] <= g_wet[32:16];
					end else if (k_q < 4'd2) begin
						gain_q[k_q[2:0]] <= g_c;
					end
					k_q <= k_q + 4'd1;
					if (k_q == 4'd5) begin
						state_q <= ST_DIV;
					end
				end

				// crossfade phase: tick * 2^16 / period, one bit a cycle
				ST_DIV: begin
					if (rem2 >= {1'b0, period_eff}) begin
						rem_q <= 9'(rem2 - {1'b0, period_eff});
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						rem_q <= rem2[8:0];
						quo_q <= {quo_q[14:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'd15) begin
						sine_start_q <= 1'b1;
						sine_sel_q   <= 1'b0;
						state_q      <= ST_SINE;
					end
				end

				// rising then falling fade weight
				ST_SINE: begin
					if (sine_done) begin
						if (!sine_sel_q) begin
							up_q         <= sine_r;
							sine_sel_q   <= 1'b1;
							sine_start_q <= 1'b1;
						end else begin
							down_q  <= sine_r;
							k_q     <= 4'd0;
							ph_q    <= 2'd0;
							acc_q   <= '0;
							state_q <= ST_MIX;
						end
					end
				end

				// weighted tap accumulation
				ST_MIX: begin
					unique case (ph_q)
						2'd0: ph_q <= 2'd1;
						2'd1: begin
							p_q  <= pf_rnd[41:16];
							ph_q <= 2'd2;
						end
						default: begin
							acc_q <= acc_q + term;
							ph_q  <= 2'd0;
							if (k_q[2:0] == last_lane) begin
								state_q <= ST_FIN0;
							end else begin
								k_q <= k_q + 4'd1;
							end
						end
					endcase
				end

				ST_FIN0: begin
					lo_q    <= 37'(acc_q[20:0]) * 37'(VIB_GAIN);
					dp_q    <= x_in_q * $signed({1'b0, dry_q});
					state_q <= ST_FIN1;
				end

				ST_FIN1: begin
					res_q   <= res_sat;
					state_q <= ST_DONE;
				end

				// hand over once the output register is free
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						sample_out_q <= res_q;
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase

			// register writes; mode and spacing restart the history pointer
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_DEPTH_MODE: begin
						mode_q <= cfg_data[1:0];
						wp_q   <= '0;
					end
					CFG_TAP_SPACING: begin
						spacing_q <= cfg_data[6:0];
						wp_q      <= '0;
					end
					CFG_DAMPING:       damping_q <= cfg_data;
					CFG_DRY_GAIN:      dry_q     <= cfg_data;
					CFG_CHORUS_ENABLE: chorus_q  <= cfg_data[0];
					CFG_SCAN_PERIOD:   period_q  <= cfg_data[8:0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/scv_ram.sv
// ----------------------------------------------------------------------------
// scv_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module scv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/scv_sine.sv
// ----------------------------------------------------------------------------
// scv_sine: iterative quarter-sine unit
// Evaluates the Q16 odd polynomial by Horner steps on one shared multiplier,
// one step at a time, with the result clamped to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module scv_sine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [16:0] x,
	output logic             done,
	output logic      [16:0] result
);

	import scv_pkg::*;

	typedef enum logic {SN_IDLE, SN_RUN} sn_state_t;

	sn_state_t   state_q;
	logic [2:0]  cnt_q;
	logic [16:0] x_q;
	logic [16:0] x2_q;
	logic [16:0] t_q;

	logic [16:0] mul_a;
	logic [16:0] mul_b;
	logic [33:0] prod;
	logic [33:0] prod_rnd;

	// shared multiplier operand select
	always_comb begin
		mul_a = t_q;
		mul_b = x2_q;
		unique case (cnt_q)
			3'd0: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			3'd1: mul_a = SIN_C7;
			3'd4: mul_b = x_q;
			default: ;
		endcase
		prod     = 34'(mul_a) * 34'(mul_b);
		prod_rnd = prod + 34'd32768;
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SN_IDLE;
			cnt_q   <= 3'd0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				SN_IDLE: begin
					if (start) begin
						x_q     <= x;
						cnt_q   <= 3'd0;
						state_q <= SN_RUN;
					end
				end
				SN_RUN: begin
					cnt_q <= cnt_q + 3'd1;
					unique case (cnt_q)
						3'd0: x2_q <= prod_rnd[32:16];
						3'd1: t_q  <= SIN_C5 - prod[32:16];
						3'd2: t_q  <= SIN_C3 - prod[32:16];
						3'd3: t_q  <= SIN_C1 - prod[32:16];
						default: begin
							result  <= (prod_rnd[33:16] > {1'b0, SIN_ONE}) ?
								SIN_ONE : prod_rnd[32:16];
							done    <= 1'b1;
							state_q <= SN_IDLE;
						end
					endcase
				end
				default: state_q <= SN_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
